// ===== rtl/core/sysc_pkg.sv =====
// Shared constants and types of the system configuration register block.
`default_nettype none

package sysc_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned INDEX_W = 5;

	// Register word indexes.
	localparam logic [INDEX_W-1:0] IDX_CLOCK     = 5'd2;
	localparam logic [INDEX_W-1:0] IDX_MISC      = 5'd6;
	localparam logic [INDEX_W-1:0] IDX_PAD_48_51 = 5'd19;
	localparam logic [INDEX_W-1:0] IDX_PAD_52_55 = 5'd20;

	// Bit positions and fields.
	localparam logic [DATA_W-1:0] CLOCK_UART0_BIT = 32'h0000_0010;
	localparam logic [DATA_W-1:0] MISC_SOFTRESET  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MISC_IRQ_SEL    = 32'h0008_0000;
	localparam logic [DATA_W-1:0] MISC_FIFO_SEL   = 32'h0010_0000;
	localparam logic [DATA_W-1:0] MISC_CLK_SEL    = 32'h0020_0000;
	localparam logic [DATA_W-1:0] PAD_FUNC_FIELDS = 32'hC0C0_C0C0;

	typedef enum logic {
		MODE_READ  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	// One bus transaction as presented to the register file.
	typedef struct packed {
		logic               valid;
		mode_t              mode;
		logic [INDEX_W-1:0] word_index;
		logic [DATA_W-1:0]  bit_mask;
		logic [DATA_W-1:0]  write_data;
	} access_t;

	// Level and pulse outputs, as they stand after the transaction.
	typedef struct packed {
		logic clock_on;
		logic pad_on;
		logic clock_select;
		logic fifo_select;
		logic irq_select;
		logic soft_reset;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sysc_regfile.sv =====
// Register storage with masked read, masked write merge and status decode.
`default_nettype none

module sysc_regfile #(
	parameter int DEPTH = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire sysc_pkg::access_t      acc,
	output logic [sysc_pkg::DATA_W-1:0] rdata,
	output sysc_pkg::status_t           status
);
	import sysc_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [INDEX_W:0] DEPTH_L = (INDEX_W+1)'(DEPTH);

	logic [DATA_W-1:0] regs_q [DEPTH];

	logic              in_range;
	logic [IDX_W-1:0]  idx;
	logic              wr_hit;
	logic [DATA_W-1:0] merged;
	logic [DATA_W-1:0] merged_clean;
	logic              pulse;
	logic [DATA_W-1:0] clock_nx;
	logic [DATA_W-1:0] misc_nx;
	logic [DATA_W-1:0] pad_a_nx;
	logic [DATA_W-1:0] pad_b_nx;

	assign in_range = ({1'b0, acc.word_index} < DEPTH_L);
	assign idx      = acc.word_index[IDX_W-1:0];
	assign wr_hit   = acc.valid && (acc.mode == MODE_WRITE) && in_range;

	always_comb begin
		merged       = (acc.write_data & acc.bit_mask) | (regs_q[idx] & ~acc.bit_mask);
		pulse        = wr_hit && (acc.word_index == IDX_MISC) &&
		               ((merged & MISC_SOFTRESET) != '0);
		// The soft-reset bit is never stored, so it always reads back as zero.
		merged_clean = pulse ? (merged & ~MISC_SOFTRESET) : merged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr_hit) begin
			regs_q[idx] <= merged_clean;
		end
	end

	always_comb begin
		if (acc.valid && (acc.mode == MODE_READ) && in_range) begin
			rdata = regs_q[idx] & acc.bit_mask;
		end else begin
			rdata = '0;
		end
	end

	// Status reflects the contents after this transaction, so the merged word bypasses the stored one.
	always_comb begin
		clock_nx = (wr_hit && acc.word_index == IDX_CLOCK) ?
		           merged_clean : regs_q[IDX_W'(IDX_CLOCK)];
		misc_nx  = (wr_hit && acc.word_index == IDX_MISC) ?
		           merged_clean : regs_q[IDX_W'(IDX_MISC)];
		pad_a_nx = (wr_hit && acc.word_index == IDX_PAD_48_51) ?
		           merged_clean : regs_q[IDX_W'(IDX_PAD_48_51)];
		pad_b_nx = (wr_hit && acc.word_index == IDX_PAD_52_55) ?
		           merged_clean : regs_q[IDX_W'(IDX_PAD_52_55)];

		status.clock_on     = (clock_nx & CLOCK_UART0_BIT) != '0;
		status.pad_on       = status.clock_on &&
		                      ((pad_a_nx & PAD_FUNC_FIELDS) == PAD_FUNC_FIELDS) &&
		                      ((pad_b_nx & PAD_FUNC_FIELDS) == PAD_FUNC_FIELDS);
		status.clock_select = (misc_nx & MISC_CLK_SEL) != '0;
		status.fifo_select  = (misc_nx & MISC_FIFO_SEL) != '0;
		status.irq_select   = (misc_nx & MISC_IRQ_SEL) != '0;
		status.soft_reset   = pulse;
	end

`ifndef SYNTHESIS
	a_misc_bit31_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(regs_q[IDX_W'(IDX_MISC)] & MISC_SOFTRESET) == '0)
		else $error("soft-reset bit stored in misc register");

	a_pulse_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		status.soft_reset |-> (acc.valid && acc.mode == MODE_WRITE))
		else $error("soft-reset pulse without a write transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/system_config_register_block_core.sv =====
// Top level of the system configuration register block.
//
// A bus transaction is offered on mode, word_index, bit_mask and write_data
// with start high, and is taken at the clock edge where start is high and
// busy is low. busy stays low, so a transaction can be taken every cycle.
// The transaction is held in an input register; in the following cycle the
// register file is read or merged and written, and the result is captured
// in the output registers. done is high for exactly one cycle, driven
// from the input register through the done register, with read_data, the
// UART0 status levels and soft_reset_pulse valid in that cycle. The status
// levels show the register contents after the transaction. Throughput is
// one transaction per cycle, set by the read-merge-write register file path.
// The receiver cannot stall; results are taken as they appear.
// Reset clears every register word to zero and drops all pending work.
// Word indexes at or beyond the bank read as zero and ignore writes.
`default_nettype none

module system_config_register_block_core #(
	parameter int REG_COUNT = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire                         mode,
	input  wire [sysc_pkg::INDEX_W-1:0] word_index,
	input  wire [sysc_pkg::DATA_W-1:0]  bit_mask,
	input  wire [sysc_pkg::DATA_W-1:0]  write_data,
	output logic                        done,
	output logic [sysc_pkg::DATA_W-1:0] read_data,
	output logic                        uart0_clock_on,
	output logic                        uart0_pad_on,
	output logic                        uart0_clock_select,
	output logic                        uart0_fifo_select,
	output logic                        uart0_irq_select,
	output logic                        soft_reset_pulse
);
	import sysc_pkg::*;

	// Only the words that a five-bit index reaches are built.
	localparam int DEPTH = (REG_COUNT < 32) ? REG_COUNT : 32;

	access_t           acc_s1;
	logic [DATA_W-1:0] rdata;
	status_t           status;
	logic              done_q;
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= '0;
		end else begin
			acc_s1.valid <= accept;
			if (accept) begin
				acc_s1.mode       <= mode_t'(mode);
				acc_s1.word_index <= word_index;
				acc_s1.bit_mask   <= bit_mask;
				acc_s1.write_data <= write_data;
			end
		end
	end

	sysc_regfile #(
		.DEPTH (DEPTH)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc_s1),
		.rdata  (rdata),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= acc_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1.valid) begin
			read_data          <= rdata;
			uart0_clock_on     <= status.clock_on;
			uart0_pad_on       <= status.pad_on;
			uart0_clock_select <= status.clock_select;
			uart0_fifo_select  <= status.fifo_select;
			uart0_irq_select   <= status.irq_select;
			soft_reset_pulse   <= status.soft_reset;
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result strobe missing two cycles after a transaction");

	a_pad_needs_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(done && uart0_pad_on) |-> uart0_clock_on)
		else $error("pad readiness reported with UART0 clock off");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_s1.valid && acc_s1.mode == MODE_WRITE) |=> (read_data == '0))
		else $error("write transaction returned non-zero read data");
`endif

endmodule

`default_nettype wire

// ===== sim/system_config_register_block_core_tb.sv =====
// Self-checking testbench of the system configuration register block top level.
`timescale 1ns / 100ps

module system_config_register_block_core_tb;

	import sysc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1830;
	localparam int TAIL_CYCLES = 8;
	localparam int BURST_FIRST = 700;
	localparam int BURST_LAST = 1000;

	typedef struct {
		mode_t             mode;
		logic [INDEX_W-1:0] index;
		logic [DATA_W-1:0]  mask;
		logic [DATA_W-1:0]  data;
	} bus_access_t;

	typedef struct {
		logic [DATA_W-1:0] read_data;
		status_t           status;
	} access_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               mode = 1'b0;
	logic [INDEX_W-1:0] word_index = '0;
	logic [DATA_W-1:0]  bit_mask = '0;
	logic [DATA_W-1:0]  write_data = '0;
	logic               busy;
	logic               done;
	logic [DATA_W-1:0]  read_data;
	logic               uart0_clock_on;
	logic               uart0_pad_on;
	logic               uart0_clock_select;
	logic               uart0_fifo_select;
	logic               uart0_irq_select;
	logic               soft_reset_pulse;

	bus_access_t    pending_accesses[$];
	access_result_t expected_results[$];
	logic [DATA_W-1:0] shadow_regs [2**INDEX_W];

	int errors = 0;
	int accepted_count = 0;
	int cycle_count = 0;
	int checked_count = 0;
	int read_count = 0;
	int write_count = 0;
	int pulse_count = 0;
	int pad_ready_count = 0;

	system_config_register_block_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.mode               (mode),
		.word_index         (word_index),
		.bit_mask           (bit_mask),
		.write_data         (write_data),
		.done               (done),
		.read_data          (read_data),
		.uart0_clock_on     (uart0_clock_on),
		.uart0_pad_on       (uart0_pad_on),
		.uart0_clock_select (uart0_clock_select),
		.uart0_fifo_select  (uart0_fifo_select),
		.uart0_irq_select   (uart0_irq_select),
		.soft_reset_pulse   (soft_reset_pulse)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one transaction to the shadow register file and returns what the block
	// should report for it; the status levels reflect the contents after the access.
	function automatic access_result_t apply_access(bus_access_t acc);
		access_result_t res;
		logic [DATA_W-1:0] merged;
		logic pads_ready;
		res.read_data = '0;
		res.status = '0;
		if (acc.mode == MODE_WRITE) begin
			merged = (acc.data & acc.mask) | (shadow_regs[acc.index] & ~acc.mask);
			if (acc.index == IDX_MISC && (merged & MISC_SOFTRESET) != '0) begin
				res.status.soft_reset = 1'b1;
				merged &= ~MISC_SOFTRESET;
			end
			shadow_regs[acc.index] = merged;
		end else begin
			res.read_data = shadow_regs[acc.index] & acc.mask;
		end
		pads_ready = ((shadow_regs[IDX_PAD_48_51] & PAD_FUNC_FIELDS) == PAD_FUNC_FIELDS)
			&& ((shadow_regs[IDX_PAD_52_55] & PAD_FUNC_FIELDS) == PAD_FUNC_FIELDS);
		res.status.clock_on = (shadow_regs[IDX_CLOCK] & CLOCK_UART0_BIT) != '0;
		res.status.pad_on = res.status.clock_on && pads_ready;
		res.status.clock_select = (shadow_regs[IDX_MISC] & MISC_CLK_SEL) != '0;
		res.status.fifo_select = (shadow_regs[IDX_MISC] & MISC_FIFO_SEL) != '0;
		res.status.irq_select = (shadow_regs[IDX_MISC] & MISC_IRQ_SEL) != '0;
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] random_word_pattern();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			return $urandom();
		end else if (pick < 50) begin
			return PAD_FUNC_FIELDS | $urandom();
		end else if (pick < 65) begin
			return '1;
		end else if (pick < 75) begin
			return '0;
		end else if (pick < 90) begin
			return 32'h1 << $urandom_range(31);
		end else begin
			return ~(32'h1 << $urandom_range(31));
		end
	endfunction

	// Half the transactions go to the clock, misc and pad registers, where the status
	// outputs are decoded; the rest spread over the whole bank.
	function automatic bus_access_t random_access();
		bus_access_t acc;
		int pick;
		acc.mode = ($urandom_range(1) == 1) ? MODE_WRITE : MODE_READ;
		pick = $urandom_range(7);
		case (pick)
			0: acc.index = IDX_CLOCK;
			1: acc.index = IDX_MISC;
			2: acc.index = IDX_PAD_48_51;
			3: acc.index = IDX_PAD_52_55;
			default: acc.index = INDEX_W'($urandom_range(2**INDEX_W - 1));
		endcase
		acc.mask = random_word_pattern();
		acc.data = random_word_pattern();
		return acc;
	endfunction

	task automatic queue_access(mode_t m, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] msk,
			logic [DATA_W-1:0] dat);
		bus_access_t acc;
		acc.mode = m;
		acc.index = idx;
		acc.mask = msk;
		acc.data = dat;
		pending_accesses.push_back(acc);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: the front of the queue is offered until the block takes it.
	always @(posedge clk) begin
		logic accepted;
		logic go_idle;
		if (arst_n) begin
			accepted = start && !busy;
			if (accepted) begin
				void'(pending_accesses.pop_front());
				accepted_count++;
			end
			if (!start || accepted) begin
				go_idle = ($urandom_range(99) < 28)
					&& !(accepted_count >= BURST_FIRST && accepted_count < BURST_LAST);
				if (pending_accesses.size() != 0 && !go_idle) begin
					start <= 1'b1;
					mode <= pending_accesses[0].mode;
					word_index <= pending_accesses[0].index;
					bit_mask <= pending_accesses[0].mask;
					write_data <= pending_accesses[0].data;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts each accepted transaction, then checks any result of this cycle.
	always @(posedge clk) begin
		access_result_t want;
		bus_access_t seen;
		if (arst_n) begin
			if (start && !busy) begin
				seen.mode = mode_t'(mode);
				seen.index = word_index;
				seen.mask = bit_mask;
				seen.data = write_data;
				expected_results.push_back(apply_access(seen));
				if (seen.mode == MODE_WRITE) write_count++;
				else read_count++;
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no transaction outstanding, read_data %h",
						$time, read_data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (want.status.soft_reset) pulse_count++;
					if (want.status.pad_on) pad_ready_count++;
					check_field("read_data", want.read_data, read_data);
					check_field("uart0_clock_on", want.status.clock_on, uart0_clock_on);
					check_field("uart0_pad_on", want.status.pad_on, uart0_pad_on);
					check_field("uart0_clock_select", want.status.clock_select,
						uart0_clock_select);
					check_field("uart0_fifo_select", want.status.fifo_select,
						uart0_fifo_select);
					check_field("uart0_irq_select", want.status.irq_select, uart0_irq_select);
					check_field("soft_reset_pulse", want.status.soft_reset, soft_reset_pulse);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d transactions pending and %0d results owed",
				$time, pending_accesses.size(), expected_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		foreach (shadow_regs[i]) shadow_regs[i] = '0;

		queue_access(MODE_READ, 5'd0, '1, '1);
		queue_access(MODE_WRITE, 5'd31, '1, '1);
		queue_access(MODE_READ, 5'd31, '1, '0);
		queue_access(MODE_READ, 5'd31, '0, '1);
		queue_access(MODE_WRITE, 5'd0, '0, '1);
		queue_access(MODE_READ, 5'd0, '1, '0);
		// Bring the UART0 pads up step by step, then knock them down and bring them up again.
		queue_access(MODE_WRITE, IDX_CLOCK, '1, CLOCK_UART0_BIT);
		queue_access(MODE_WRITE, IDX_PAD_48_51, PAD_FUNC_FIELDS, PAD_FUNC_FIELDS);
		queue_access(MODE_WRITE, IDX_PAD_52_55, '1, '1);
		queue_access(MODE_WRITE, IDX_PAD_52_55, 32'h0000_0080, '0);
		queue_access(MODE_WRITE, IDX_PAD_52_55, 32'h0000_0080, 32'h0000_0080);
		queue_access(MODE_WRITE, IDX_CLOCK, CLOCK_UART0_BIT, '0);
		queue_access(MODE_WRITE, IDX_CLOCK, CLOCK_UART0_BIT, '1);
		queue_access(MODE_WRITE, IDX_MISC, '1, MISC_CLK_SEL | MISC_FIFO_SEL | MISC_IRQ_SEL);
		// The soft-reset bit pulses and must never be stored.
		queue_access(MODE_WRITE, IDX_MISC, MISC_SOFTRESET, '1);
		queue_access(MODE_READ, IDX_MISC, '1, '0);
		queue_access(MODE_WRITE, IDX_MISC, ~MISC_SOFTRESET, '1);
		queue_access(MODE_WRITE, IDX_MISC, MISC_SOFTRESET, '0);
		queue_access(MODE_READ, IDX_MISC, MISC_SOFTRESET, '1);
		queue_access(MODE_WRITE, IDX_MISC, '1, '0);
		queue_access(MODE_READ, IDX_PAD_48_51, 32'hAAAA_AAAA, 32'h1234_5678);
		queue_access(MODE_WRITE, 5'd5, 32'hFFFF_0000, 32'hA5A5_5A5A);
		queue_access(MODE_READ, 5'd5, '1, '0);
		repeat (RANDOM_ITEMS) pending_accesses.push_back(random_access());

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_accesses.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Checked %0d results from %0d reads and %0d writes in %0d cycles.",
			checked_count, read_count, write_count, cycle_count);
		$display("Soft-reset pulses expected: %0d; results with UART0 pads ready: %0d.",
			pulse_count, pad_ready_count);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sysc_pkg.sv
rtl/core/sysc_regfile.sv
rtl/core/system_config_register_block_core.sv
sim/system_config_register_block_core_tb.sv
